// File: sv/serial_line_editor_unit_assert.svh
// Assertion macros used by the checker file of the serial line editor.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef SERIAL_LINE_EDITOR_UNIT_ASSERT_SVH
`define SERIAL_LINE_EDITOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SLE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/sle_pkg.sv
// Package of the serial line editor: item types, command and byte codes,
// and the result plan passed from the control logic to the result sequencer.
`default_nettype none
package sle_pkg;

	localparam int LINE_BYTES_DEF = 256;

	localparam logic [1:0] CMD_RX      = 2'd0;
	localparam logic [1:0] CMD_READ    = 2'd1;
	localparam logic [1:0] CMD_RELEASE = 2'd2;

	localparam logic [7:0] BYTE_BS = 8'h08;
	localparam logic [7:0] BYTE_LF = 8'h0A;
	localparam logic [7:0] BYTE_CR = 8'h0D;
	localparam logic [7:0] BYTE_SP = 8'h20;

	// Shape of the result sequence an item produces.
	localparam logic [1:0] KIND_PLAIN = 2'd0;
	localparam logic [1:0] KIND_ECHO  = 2'd1;
	localparam logic [1:0] KIND_CRLF  = 2'd2;
	localparam logic [1:0] KIND_BS3   = 2'd3;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] rx_byte;
		logic [7:0] read_index;
	} in_item_t;

	typedef struct packed {
		logic       echo_valid;
		logic [7:0] echo_byte;
		logic [7:0] read_data;
		logic       line_ready;
		logic [7:0] line_length;
		logic       byte_dropped;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] echo_byte;
		logic       rd_hit;
		logic       line_ready;
		logic [7:0] line_length;
		logic       byte_dropped;
	} plan_t;

endpackage
`default_nettype wire

// File: sv/sle_result_seq.sv
// Result sequencer of the serial line editor: holds one item's plan and
// steps it out as one to three result items through an output register.
// Depends on sle_pkg.
`default_nettype none
module sle_result_seq (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                load,
	input  wire sle_pkg::plan_t plan,
	input  wire  [7:0]         rd_data,
	output logic               busy,
	output logic               rsp_valid,
	input  wire                rsp_stall,
	output sle_pkg::out_item_t rsp
);

	sle_pkg::plan_t     plan_s1;
	logic               valid_s1;
	logic [1:0]         step_s1;
	logic               advance;
	logic               is_last;
	sle_pkg::out_item_t result;
	sle_pkg::out_item_t out_q;
	logic               out_valid_q;

	assign advance = valid_s1 && (!out_valid_q || !rsp_stall);
	assign busy    = valid_s1 && !(advance && is_last);

	always_comb begin
		result              = '0;
		result.read_data    = plan_s1.rd_hit ? rd_data : 8'h00;
		result.line_ready   = plan_s1.line_ready;
		result.line_length  = plan_s1.line_length;
		result.byte_dropped = plan_s1.byte_dropped;
		is_last             = 1'b1;
		case (plan_s1.kind)
			sle_pkg::KIND_PLAIN: begin
				is_last = 1'b1;
			end
			sle_pkg::KIND_ECHO: begin
				result.echo_valid = 1'b1;
				result.echo_byte  = plan_s1.echo_byte;
			end
			sle_pkg::KIND_CRLF: begin
				result.echo_valid = 1'b1;
				result.echo_byte  = (step_s1 == 2'd0) ? sle_pkg::BYTE_CR : sle_pkg::BYTE_LF;
				is_last           = (step_s1 == 2'd1);
			end
			sle_pkg::KIND_BS3: begin
				result.echo_valid = 1'b1;
				result.echo_byte  = (step_s1 == 2'd1) ? sle_pkg::BYTE_SP : sle_pkg::BYTE_BS;
				is_last           = (step_s1 == 2'd2);
			end
			default: begin
				is_last = 1'b1;
			end
		endcase
		result.last = is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			step_s1     <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_s1 <= 1'b1;
				step_s1  <= 2'd0;
			end else if (advance) begin
				if (is_last) begin
					valid_s1 <= 1'b0;
				end
				step_s1 <= step_s1 + 2'd1;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			plan_s1 <= plan;
		end
		if (advance) begin
			out_q <= result;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule
`default_nettype wire

// File: sv/serial_line_editor_unit.sv
// Serial line editor: an accepted item updates the fill count and lock at once and
// touches the line store in the same cycle; its plan is registered in the sequencer
// and its results pass through the output register, one per cycle while rsp_stall
// is low. An item yields 1 to 3 results (echo plan length); the next item is taken
// as its last result moves out. Reset clears the fill count, the lock and the pipeline;
// the line store is not cleared, since only entries below the fill count are returned.
`default_nettype none
module serial_line_editor_unit #(
	parameter int LINE_BYTES = sle_pkg::LINE_BYTES_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                req_valid,
	output logic               req_stall,
	input  wire sle_pkg::in_item_t req,
	output logic               rsp_valid,
	input  wire                rsp_stall,
	output sle_pkg::out_item_t rsp
);

	localparam int         AW  = $clog2(LINE_BYTES);
	localparam logic [7:0] CAP = 8'((LINE_BYTES < 255) ? LINE_BYTES : 255);

	logic [7:0]     mem [LINE_BYTES];
	logic [7:0]     rdata_q;
	logic [7:0]     fill_q;
	logic           locked_q;
	logic [7:0]     fill_d;
	logic           locked_d;
	logic           accept;
	logic           seq_busy;
	logic           we;
	logic           re;
	logic [AW+7:0]  waddr_ext;
	logic [AW+7:0]  raddr_ext;
	sle_pkg::plan_t plan;

	assign accept    = req_valid && !req_stall;
	assign req_stall = seq_busy;

	assign waddr_ext = {{AW{1'b0}}, fill_q};
	assign raddr_ext = {{AW{1'b0}}, req.read_index};

	always_comb begin
		fill_d            = fill_q;
		locked_d          = locked_q;
		we                = 1'b0;
		re                = 1'b0;
		plan              = '0;
		plan.kind         = sle_pkg::KIND_PLAIN;
		plan.echo_byte    = req.rx_byte;
		case (req.command)
			sle_pkg::CMD_READ: begin
				re          = 1'b1;
				plan.rd_hit = (req.read_index < fill_q);
			end
			sle_pkg::CMD_RELEASE: begin
				if (locked_q) begin
					locked_d = 1'b0;
					fill_d   = 8'd0;
				end
			end
			sle_pkg::CMD_RX: begin
				if (locked_q) begin
					plan.byte_dropped = 1'b1;
				end else if (req.rx_byte == sle_pkg::BYTE_CR) begin
					locked_d  = 1'b1;
					plan.kind = sle_pkg::KIND_CRLF;
				end else if (req.rx_byte >= sle_pkg::BYTE_SP) begin
					if (fill_q < CAP) begin
						we     = 1'b1;
						fill_d = fill_q + 8'd1;
					end
					plan.kind = sle_pkg::KIND_ECHO;
				end else if (req.rx_byte == sle_pkg::BYTE_BS) begin
					if (fill_q != 8'd0) begin
						fill_d    = fill_q - 8'd1;
						plan.kind = sle_pkg::KIND_BS3;
					end
				end else begin
					// Any other control byte throws the line away and locks it empty.
					fill_d    = 8'd0;
					locked_d  = 1'b1;
					plan.kind = sle_pkg::KIND_CRLF;
				end
			end
			default: begin
				plan.kind = sle_pkg::KIND_PLAIN;
			end
		endcase
		plan.line_ready  = locked_d;
		plan.line_length = fill_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= 8'd0;
			locked_q <= 1'b0;
		end else if (accept) begin
			fill_q   <= fill_d;
			locked_q <= locked_d;
		end
	end

	// Reads and writes come from different commands, so one item never does both.
	always_ff @(posedge clk) begin
		if (accept && we) begin
			mem[waddr_ext[AW-1:0]] <= req.rx_byte;
		end
		if (accept && re) begin
			rdata_q <= mem[raddr_ext[AW-1:0]];
		end
	end

	sle_result_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.plan      (plan),
		.rd_data   (rdata_q),
		.busy      (seq_busy),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

// File: sv/sle_checker.sv
// Port-level checker of the serial line editor and its bind to the top level.
// Depends on sle_pkg and serial_line_editor_unit_assert.svh.
`default_nettype none
`include "serial_line_editor_unit_assert.svh"
module sle_checker (
	input wire                     clk,
	input wire                     arst_n,
	input wire                     rsp_valid,
	input wire                     rsp_stall,
	input wire sle_pkg::out_item_t rsp
);

	// A stalled result must hold until taken.
	`SLE_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled result changed")
	`SLE_ASSERT_IMP(a_echo_zero, clk, arst_n, rsp_valid && !rsp.echo_valid, rsp.echo_byte == 8'h00, "echo byte set without echo")
	`SLE_ASSERT_IMP(a_drop_shape, clk, arst_n, rsp_valid && rsp.byte_dropped, rsp.line_ready && !rsp.echo_valid && rsp.last, "dropped item result malformed")
	`SLE_ASSERT_IMP(a_multi_echo, clk, arst_n, rsp_valid && !rsp.last, rsp.echo_valid, "non-final result without echo")
	// The rest of an echo sequence follows without a gap.
	`SLE_ASSERT_NXT(a_seq_gapless, clk, arst_n, rsp_valid && !rsp_stall && !rsp.last, rsp_valid, "gap inside echo sequence")

endmodule

bind serial_line_editor_unit sle_checker u_sle_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
`default_nettype wire

// File: bench/tb_top.sv
// Self-checking testbench for serial_line_editor_unit: typed, read and released lines.
// Depends on sle_pkg for the item types, command codes and byte codes.
// Expected results are predicted per item and checked as they leave the block.
`default_nettype none
module tb_top;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int CAPACITY = (sle_pkg::LINE_BYTES_DEF < 255) ? sle_pkg::LINE_BYTES_DEF : 255;
	localparam int RANDOM_ITEMS = 50;
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int REPORT_MAX = 10;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	sle_pkg::in_item_t  req = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	sle_pkg::out_item_t rsp;

	// Line state as the block should hold it.
	logic [7:0] line_copy [0:255];
	int         line_len = 0;
	bit         line_locked = 1'b0;

	sle_pkg::out_item_t line_results_q [$];
	int         mismatches = 0;
	int         results_checked = 0;
	int         items_sent = 0;
	int         lines_locked = 0;
	int         full_echoes = 0;
	int         cycles = 0;
	bit         sender_gaps = 1'b1;
	bit         rsp_gaps = 1'b1;
	int unsigned hold_len = 0;

	serial_line_editor_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int unsigned pick_gap();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(0, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic sle_pkg::in_item_t make_item(logic [1:0] cmd, logic [7:0] rx,
		logic [7:0] idx);
		sle_pkg::in_item_t it;
		it.command = cmd;
		it.rx_byte = rx;
		it.read_index = idx;
		return it;
	endfunction

	function automatic void push_result(bit ev, logic [7:0] eb, logic [7:0] rd, bit dropped,
		bit is_last);
		sle_pkg::out_item_t r;
		r.echo_valid = ev;
		r.echo_byte = ev ? eb : 8'h00;
		r.read_data = rd;
		r.line_ready = line_locked;
		r.line_length = line_len[7:0];
		r.byte_dropped = dropped;
		r.last = is_last;
		line_results_q.push_back(r);
	endfunction

	// Applies one item to the line state and queues the results it should cause.
	function automatic void edit_line(sle_pkg::in_item_t it);
		logic [7:0] rd;
		case (it.command)
			sle_pkg::CMD_READ: begin
				rd = (int'(it.read_index) < line_len) ? line_copy[it.read_index] : 8'h00;
				push_result(1'b0, 8'h00, rd, 1'b0, 1'b1);
			end
			sle_pkg::CMD_RELEASE: begin
				if (line_locked) begin
					line_locked = 1'b0;
					line_len = 0;
				end
				push_result(1'b0, 8'h00, 8'h00, 1'b0, 1'b1);
			end
			sle_pkg::CMD_RX: begin
				if (line_locked) begin
					push_result(1'b0, 8'h00, 8'h00, 1'b1, 1'b1);
				end else if (it.rx_byte == sle_pkg::BYTE_CR) begin
					line_locked = 1'b1;
					lines_locked++;
					push_result(1'b1, sle_pkg::BYTE_CR, 8'h00, 1'b0, 1'b0);
					push_result(1'b1, sle_pkg::BYTE_LF, 8'h00, 1'b0, 1'b1);
				end else if (it.rx_byte >= sle_pkg::BYTE_SP) begin
					if (line_len < CAPACITY) begin
						line_copy[line_len[7:0]] = it.rx_byte;
						line_len++;
					end else begin
						full_echoes++;
					end
					push_result(1'b1, it.rx_byte, 8'h00, 1'b0, 1'b1);
				end else if (it.rx_byte == sle_pkg::BYTE_BS) begin
					if (line_len == 0) begin
						push_result(1'b0, 8'h00, 8'h00, 1'b0, 1'b1);
					end else begin
						line_len--;
						push_result(1'b1, sle_pkg::BYTE_BS, 8'h00, 1'b0, 1'b0);
						push_result(1'b1, sle_pkg::BYTE_SP, 8'h00, 1'b0, 1'b0);
						push_result(1'b1, sle_pkg::BYTE_BS, 8'h00, 1'b0, 1'b1);
					end
				end else begin
					// Any other control byte throws the line away but still locks it.
					line_len = 0;
					line_locked = 1'b1;
					lines_locked++;
					push_result(1'b1, sle_pkg::BYTE_CR, 8'h00, 1'b0, 1'b0);
					push_result(1'b1, sle_pkg::BYTE_LF, 8'h00, 1'b0, 1'b1);
				end
			end
			default: push_result(1'b0, 8'h00, 8'h00, 1'b0, 1'b1);
		endcase
	endfunction

	task automatic idle_sender(int unsigned n);
		if (n != 0) begin
			req_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Called at a rising edge; valid stays high on return unless an idle gap follows, so items can go back to back.
	task automatic send_item(sle_pkg::in_item_t it);
		req_valid <= 1'b1;
		req <= it;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		edit_line(it);
		items_sent++;
		if (sender_gaps)
			idle_sender(pick_gap());
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (line_results_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_rx(logic [7:0] b);
		send_item(make_item(sle_pkg::CMD_RX, b, 8'($urandom_range(0, 255))));
	endtask

	task automatic send_read(logic [7:0] idx);
		send_item(make_item(sle_pkg::CMD_READ, 8'($urandom_range(0, 255)), idx));
	endtask

	task automatic send_release();
		send_item(make_item(sle_pkg::CMD_RELEASE, 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255))));
	endtask

	task automatic test_directed();
		send_rx(sle_pkg::BYTE_BS);
		send_rx(8'h20);
		send_rx(8'hFF);
		send_rx(8'h7E);
		send_rx(8'h80);
		send_read(8'd0);
		send_read(8'd3);
		send_read(8'd4);
		send_read(8'd255);
		send_rx(sle_pkg::BYTE_BS);
		send_release();
		send_item(make_item(CMD_UNUSED, 8'hFF, 8'hFF));
		send_rx(sle_pkg::BYTE_CR);
		send_read(8'd2);
		send_rx(8'h41);
		send_rx(sle_pkg::BYTE_CR);
		send_release();
		send_read(8'd0);
		send_rx(8'h41);
		send_rx(8'h00);
		send_release();
		send_rx(8'h1F);
		send_release();
		send_rx(sle_pkg::BYTE_LF);
		send_release();
		send_rx(8'h7F);
		wait_drained();
	endtask

	// Overfills the line so that the last printable bytes are echoed but not stored.
	task automatic test_full_line();
		send_release();
		repeat (CAPACITY + 3) send_rx(8'($urandom_range(32, 255)));
		send_read(8'd0);
		send_read(8'(CAPACITY - 1));
		send_read(8'd255);
		send_read(8'($urandom_range(0, 255)));
		send_rx(sle_pkg::BYTE_BS);
		send_rx(8'($urandom_range(32, 255)));
		send_rx(8'($urandom_range(32, 255)));
		send_rx(sle_pkg::BYTE_CR);
		send_read(8'(CAPACITY - 1));
		send_release();
		wait_drained();
	endtask

	// The receiver holds off while the sender keeps offering, so the block backs up.
	task automatic test_backpressure();
		sender_gaps = 1'b0;
		hold_len = 200;
		repeat (8) begin
			send_rx(8'($urandom_range(32, 255)));
			send_rx(sle_pkg::BYTE_BS);
			send_read(8'($urandom_range(0, 7)));
		end
		send_rx(sle_pkg::BYTE_CR);
		send_release();
		sender_gaps = 1'b1;
		wait_drained();
	endtask

	task automatic test_random_lines();
		int sent;
		int len;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			// Now and then a stretch without idling on the sender side, the receiver side or both.
			sender_gaps = ($urandom_range(0, 3) != 0);
			rsp_gaps = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 9) < 7) begin
				len = $urandom_range(0, 12);
				repeat (len) begin
					if ($urandom_range(0, 4) != 0)
						send_rx(8'($urandom_range(32, 255)));
					else
						send_rx(sle_pkg::BYTE_BS);
					sent++;
				end
				if ($urandom_range(0, 4) != 0)
					send_rx(sle_pkg::BYTE_CR);
				else
					send_rx(8'($urandom_range(0, 31)));
				sent++;
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(0, 3) != 0)
						send_read(8'($urandom_range(0, len + 1)));
					else
						send_read(8'($urandom_range(0, 255)));
					sent++;
				end
				if ($urandom_range(0, 3) == 0) begin
					send_rx(8'($urandom_range(0, 255)));
					sent++;
				end
				send_release();
				sent++;
			end else begin
				send_item(make_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255))));
				sent++;
			end
		end
		sender_gaps = 1'b1;
		rsp_gaps = 1'b1;
		wait_drained();
	endtask

	initial begin : receiver
		int unsigned run;
		forever begin
			@(posedge clk);
			if (hold_len != 0) begin
				rsp_stall <= 1'b1;
				run = hold_len;
				hold_len = 0;
			end else if (!rsp_gaps || $urandom_range(0, 2) != 0) begin
				rsp_stall <= 1'b0;
				run = $urandom_range(1, 4);
			end else begin
				rsp_stall <= 1'b1;
				run = pick_gap() + 1;
			end
			repeat (run - 1) @(posedge clk);
		end
	end

	always @(posedge clk) begin : check_results
		sle_pkg::out_item_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			results_checked++;
			if (line_results_q.size() == 0) begin
				if (mismatches < REPORT_MAX)
					$display("unexpected result: ev=%0b eb=%h rd=%h rdy=%0b len=%0d drop=%0b last=%0b",
						rsp.echo_valid, rsp.echo_byte, rsp.read_data, rsp.line_ready,
						rsp.line_length, rsp.byte_dropped, rsp.last);
				mismatches++;
			end else begin
				want = line_results_q.pop_front();
				if (rsp.echo_valid !== want.echo_valid || rsp.echo_byte !== want.echo_byte ||
					rsp.read_data !== want.read_data || rsp.line_ready !== want.line_ready ||
					rsp.line_length !== want.line_length ||
					rsp.byte_dropped !== want.byte_dropped || rsp.last !== want.last) begin
					if (mismatches < REPORT_MAX) begin
						$display("mismatch exp: ev=%0b eb=%h rd=%h rdy=%0b len=%0d drop=%0b last=%0b",
							want.echo_valid, want.echo_byte, want.read_data, want.line_ready,
							want.line_length, want.byte_dropped, want.last);
						$display("         got: ev=%0b eb=%h rd=%h rdy=%0b len=%0d drop=%0b last=%0b",
							rsp.echo_valid, rsp.echo_byte, rsp.read_data, rsp.line_ready,
							rsp.line_length, rsp.byte_dropped, rsp.last);
					end
					mismatches++;
				end
			end
		end
	end

	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycles,
			line_results_q.size());
		$display("serial_line_editor_unit verification failed");
		$finish;
	end

	initial begin : main
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_line();
		test_backpressure();
		test_random_lines();
		mismatches += line_results_q.size();
		$display("%0d items in, %0d results checked, %0d lines locked, %0d echoes on a full line",
			items_sent, results_checked, lines_locked, full_echoes);
		if (mismatches == 0)
			$display("serial_line_editor_unit verification clean");
		else
			$display("serial_line_editor_unit verification failed");
		$finish;
	end

endmodule
`default_nettype wire

// File: sim.f
+incdir+sv
sv/sle_pkg.sv
sv/sle_result_seq.sv
sv/serial_line_editor_unit.sv
sv/sle_checker.sv
bench/tb_top.sv
